FILE: rtl/mi3_pkg.sv
package mi3_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS = 16;
	localparam int NUM_ELEM = 9;
	// exact cofactor, determinant and dividend widths
	localparam int PROD_W = 2 * DATA_WIDTH + 1;
	localparam int DET_W = 3 * DATA_WIDTH + 2;
	localparam int NUM_W = 4 * DATA_WIDTH + 4;
	// quotient bits kept: two guard bits above the signed range
	localparam int QUO_W = DATA_WIDTH + 2;
	localparam int QUEUE_DEPTH = 2;

	typedef logic signed [DATA_WIDTH-1:0] elem_t;

	typedef struct packed {
		elem_t col0_x;
		elem_t col0_y;
		elem_t col0_z;
		elem_t col1_x;
		elem_t col1_y;
		elem_t col1_z;
		elem_t col2_x;
		elem_t col2_y;
		elem_t col2_z;
	} in_word_t;

	typedef struct packed {
		elem_t res0_x;
		elem_t res0_y;
		elem_t res0_z;
		elem_t res1_x;
		elem_t res1_y;
		elem_t res1_z;
		elem_t res2_x;
		elem_t res2_y;
		elem_t res2_z;
		logic  singular;
		logic  saturated;
	} out_word_t;

	// cofactors indexed row * 3 + column, row = cross product number
	typedef struct packed {
		logic [NUM_ELEM-1:0][PROD_W-1:0] adj;
		logic [DET_W-1:0]                det;
		logic                            singular;
	} job_t;

endpackage

FILE: rtl/matrix_inverse_3x3_top.sv
// channel   | handshake          | word
// ----------+--------------------+--------------------------------------------
// matrix    | push / full        | three columns, signed q16.16 elements
// inverse   | pop / empty        | inverse columns, singular, saturated
//
// front: one multiplier (33 x 32) forms the nine cofactors and the determinant
//   of each matrix, with a one-word input register ahead of it
// back: one restoring divider; each element is a load that adds the rounding
//   half, 34 quotient bits, then clamp and sign; a singular matrix skips it
// a two-word queue sits between the two; sustained rate is set by the divider
// reset clears only control state; each side stalls on its own through the queue
module matrix_inverse_3x3_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  mi3_pkg::in_word_t  matrix,
	output logic               empty,
	input  logic               pop,
	output mi3_pkg::out_word_t inverse
);
	import mi3_pkg::*;

	// front to queue
	job_t front_job;
	logic front_push;
	logic queue_full;
	// queue to back
	job_t head_job;
	logic queue_empty;
	logic back_pop;

	mi3_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.matrix   (matrix),
		.job      (front_job),
		.job_push (front_push),
		.job_full (queue_full)
	);

	mi3_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (front_push),
		.wr_data (front_job),
		.full    (queue_full),
		.rd      (back_pop),
		.rd_data (head_job),
		.empty   (queue_empty)
	);

	// result word is registered; the divider runs on while it waits
	mi3_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (head_job),
		.job_empty (queue_empty),
		.job_pop   (back_pop),
		.inverse   (inverse),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

FILE: rtl/mi3_front.sv
module mi3_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  mi3_pkg::in_word_t matrix,
	output mi3_pkg::job_t    job,
	output logic             job_push,
	input  logic             job_full
);
	import mi3_pkg::*;

	localparam int COF_STEPS = 2 * NUM_ELEM;
	localparam int MUL_STEPS = COF_STEPS + 6;
	localparam int EMIT_STEP = MUL_STEPS + 1;
	localparam int STEP_W = $clog2(EMIT_STEP + 1);

	in_word_t hold_q;
	logic     hold_vld_q;
	in_word_t m_q;
	logic     busy_q;
	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] used;

	logic signed [DATA_WIDTH:0]   op_a;
	elem_t                        op_b;
	logic signed [PROD_W-1:0]     prod;
	logic signed [PROD_W-1:0]     p_s1;
	logic signed [PROD_W-1:0]     acc_q;
	logic [PROD_W-1:0]            adj_q [NUM_ELEM];
	logic signed [DET_W-1:0]      det_q;
	logic signed [DET_W-1:0]      dext;
	logic                         load;

	function automatic logic signed [DATA_WIDTH:0] sx(input elem_t e);
		return {e[DATA_WIDTH-1], e};
	endfunction

	function automatic logic signed [DATA_WIDTH:0] lo_part(input logic [PROD_W-1:0] c);
		return {1'b0, c[DATA_WIDTH-1:0]};
	endfunction

	function automatic logic signed [DATA_WIDTH:0] hi_part(input logic [PROD_W-1:0] c);
		return c[PROD_W-1:DATA_WIDTH];
	endfunction

	// operand schedule: cofactor pairs, then split cofactor times column 2
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (step_q)
			0:  begin op_a = sx(m_q.col1_y); op_b = m_q.col2_z; end
			1:  begin op_a = sx(m_q.col1_z); op_b = m_q.col2_y; end
			2:  begin op_a = sx(m_q.col1_z); op_b = m_q.col2_x; end
			3:  begin op_a = sx(m_q.col1_x); op_b = m_q.col2_z; end
			4:  begin op_a = sx(m_q.col1_x); op_b = m_q.col2_y; end
			5:  begin op_a = sx(m_q.col1_y); op_b = m_q.col2_x; end
			6:  begin op_a = sx(m_q.col2_y); op_b = m_q.col0_z; end
			7:  begin op_a = sx(m_q.col2_z); op_b = m_q.col0_y; end
			8:  begin op_a = sx(m_q.col2_z); op_b = m_q.col0_x; end
			9:  begin op_a = sx(m_q.col2_x); op_b = m_q.col0_z; end
			10: begin op_a = sx(m_q.col2_x); op_b = m_q.col0_y; end
			11: begin op_a = sx(m_q.col2_y); op_b = m_q.col0_x; end
			12: begin op_a = sx(m_q.col0_y); op_b = m_q.col1_z; end
			13: begin op_a = sx(m_q.col0_z); op_b = m_q.col1_y; end
			14: begin op_a = sx(m_q.col0_z); op_b = m_q.col1_x; end
			15: begin op_a = sx(m_q.col0_x); op_b = m_q.col1_z; end
			16: begin op_a = sx(m_q.col0_x); op_b = m_q.col1_y; end
			17: begin op_a = sx(m_q.col0_y); op_b = m_q.col1_x; end
			18: begin op_a = lo_part(adj_q[6]); op_b = m_q.col2_x; end
			19: begin op_a = hi_part(adj_q[6]); op_b = m_q.col2_x; end
			20: begin op_a = lo_part(adj_q[7]); op_b = m_q.col2_y; end
			21: begin op_a = hi_part(adj_q[7]); op_b = m_q.col2_y; end
			22: begin op_a = lo_part(adj_q[8]); op_b = m_q.col2_z; end
			23: begin op_a = hi_part(adj_q[8]); op_b = m_q.col2_z; end
			default: begin op_a = '0; op_b = '0; end
		endcase
	end

	assign prod = op_a * op_b;
	assign used = step_q - STEP_W'(1);
	assign dext = {{(DET_W - PROD_W){p_s1[PROD_W-1]}}, p_s1};
	assign load = !busy_q && hold_vld_q;
	assign full = hold_vld_q;
	assign job_push = busy_q && (step_q == STEP_W'(EMIT_STEP));

	always_comb begin
		for (int i = 0; i < NUM_ELEM; i++) begin
			job.adj[i] = adj_q[i];
		end
		job.det = det_q;
		job.singular = (det_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_vld_q <= 1'b0;
			busy_q <= 1'b0;
			step_q <= '0;
		end else begin
			if (push && !hold_vld_q) begin
				hold_vld_q <= 1'b1;
			end else if (load) begin
				hold_vld_q <= 1'b0;
			end
			if (load) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q != STEP_W'(EMIT_STEP)) begin
					step_q <= step_q + STEP_W'(1);
				end else if (!job_full) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && !hold_vld_q) begin
			hold_q <= matrix;
		end
		if (load) begin
			m_q <= hold_q;
			det_q <= '0;
		end else if (busy_q) begin
			if (step_q < STEP_W'(MUL_STEPS)) begin
				p_s1 <= prod;
			end
			if (step_q != '0 && step_q <= STEP_W'(MUL_STEPS)) begin
				if (used < STEP_W'(COF_STEPS)) begin
					if (!used[0]) begin
						acc_q <= p_s1;
					end else begin
						adj_q[used[STEP_W-1:1]] <= acc_q - p_s1;
					end
				end else if (used[0]) begin
					det_q <= det_q + (dext <<< DATA_WIDTH);
				end else begin
					det_q <= det_q + dext;
				end
			end
		end
	end

endmodule

FILE: rtl/mi3_queue.sv
module mi3_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  mi3_pkg::job_t wr_data,
	output logic          full,
	input  logic          rd,
	output mi3_pkg::job_t rd_data,
	output logic          empty
);
	import mi3_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

FILE: rtl/mi3_back.sv
module mi3_back (
	input  logic              clk,
	input  logic              arst_n,
	input  mi3_pkg::job_t     job,
	input  logic              job_empty,
	output logic              job_pop,
	output mi3_pkg::out_word_t inverse,
	output logic              empty,
	input  logic              pop
);
	import mi3_pkg::*;

	localparam int ELEM_W = $clog2(NUM_ELEM);
	localparam int CNT_W = $clog2(QUO_W);

	typedef enum logic [2:0] {ST_IDLE, ST_LOAD, ST_DIV, ST_FIN, ST_DONE} state_t;

	state_t            state_q;
	job_t              job_q;
	logic [DET_W-1:0]  dabs_q;
	logic              dneg_q;
	logic              neg_q;
	logic [NUM_W-1:0]  r_q;
	logic [NUM_W-1:0]  dsh_q;
	logic [QUO_W-1:0]  q_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ELEM_W-1:0] e_q;
	elem_t             res_q [NUM_ELEM];
	logic              sing_q;
	logic              sat_q;
	out_word_t         out_q;
	logic              ovld_q;

	logic [ELEM_W-1:0] kidx;
	logic [PROD_W-1:0] cof;
	logic [PROD_W-1:0] cmag;
	logic [NUM_W-1:0]  numer;
	logic              ge;
	logic [QUO_W-1:0]  lim;
	logic              sat;
	logic [QUO_W-1:0]  mag;
	logic [QUO_W-1:0]  val;
	logic              out_free;

	// result element order is column-major over the cofactor rows
	function automatic logic [ELEM_W-1:0] cof_index(input logic [ELEM_W-1:0] e);
		logic [ELEM_W-1:0] k;
		case (e)
			0: k = ELEM_W'(0);
			1: k = ELEM_W'(3);
			2: k = ELEM_W'(6);
			3: k = ELEM_W'(1);
			4: k = ELEM_W'(4);
			5: k = ELEM_W'(7);
			6: k = ELEM_W'(2);
			7: k = ELEM_W'(5);
			default: k = ELEM_W'(8);
		endcase
		return k;
	endfunction

	assign kidx = cof_index(e_q);
	assign cof = job_q.adj[kidx];
	assign cmag = cof[PROD_W-1] ? (~cof + PROD_W'(1)) : cof;
	assign numer = (NUM_W'(cmag) << (2 * FRAC_BITS + 1)) + NUM_W'(dabs_q);
	assign ge = (r_q >= dsh_q);
	assign lim = neg_q ? (QUO_W'(1) << (DATA_WIDTH - 1))
	                   : ((QUO_W'(1) << (DATA_WIDTH - 1)) - QUO_W'(1));
	assign sat = (q_q > lim);
	assign mag = sat ? lim : q_q;
	assign val = neg_q ? (~mag + QUO_W'(1)) : mag;
	assign out_free = !ovld_q || pop;
	assign job_pop = (state_q == ST_IDLE) && !job_empty;
	assign inverse = out_q;
	assign empty = !ovld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ovld_q <= 1'b0;
		end else begin
			// a pop while the next word is loaded leaves the valid flag set for it
			if (pop && ovld_q && state_q != ST_DONE) begin
				ovld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!job_empty) begin
						job_q <= job;
						dneg_q <= job.det[DET_W-1];
						dabs_q <= job.det[DET_W-1] ? (~job.det + DET_W'(1)) : job.det;
						e_q <= '0;
						sat_q <= 1'b0;
						sing_q <= job.singular;
						if (job.singular) begin
							for (int i = 0; i < NUM_ELEM; i++) begin
								res_q[i] <= '0;
							end
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_LOAD;
						end
					end
				end
				ST_LOAD: begin
					r_q <= numer;
					dsh_q <= NUM_W'(dabs_q) << QUO_W;
					q_q <= '0;
					cnt_q <= '0;
					neg_q <= cof[PROD_W-1] ^ dneg_q;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (ge) begin
						r_q <= r_q - dsh_q;
					end
					q_q <= {q_q[QUO_W-2:0], ge};
					dsh_q <= dsh_q >> 1;
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(QUO_W - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					res_q[e_q] <= val[DATA_WIDTH-1:0];
					sat_q <= sat_q | sat;
					if (e_q == ELEM_W'(NUM_ELEM - 1)) begin
						state_q <= ST_DONE;
					end else begin
						e_q <= e_q + ELEM_W'(1);
						state_q <= ST_LOAD;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_q.res0_x <= res_q[0];
						out_q.res0_y <= res_q[1];
						out_q.res0_z <= res_q[2];
						out_q.res1_x <= res_q[3];
						out_q.res1_y <= res_q[4];
						out_q.res1_z <= res_q[5];
						out_q.res2_x <= res_q[6];
						out_q.res2_y <= res_q[7];
						out_q.res2_z <= res_q[8];
						out_q.singular <= sing_q;
						out_q.saturated <= sat_q;
						ovld_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_sing_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(ovld_q && out_q.singular) |-> !out_q.saturated)
		else $error("singular word flagged saturated");
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cnt_q < CNT_W'(QUO_W)))
		else $error("divider step count overran");
	a_elem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> (e_q < ELEM_W'(NUM_ELEM) && !job_q.singular))
		else $error("divider started on bad element");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |=> (state_q == ST_LOAD || state_q == ST_DONE))
		else $error("job taken without starting");
`endif

endmodule
